[hdl/bmhq_pkg.sv]
// shared types and constants for the binary max heap queue
// no dependencies; used by binary_max_heap_queue
`timescale 1ns / 1ps

package bmhq_pkg;

  localparam int DATA_W      = 32;
  localparam int COUNT_W     = 7;
  localparam int OUT_TDATA_W = 72;  // popped, top, count, one pad bit
  localparam int OUT_TUSER_W = 3;   // is_empty, status

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

endpackage

[hdl/binary_max_heap_queue.sv]
// binary max heap priority queue: sequencer, hole register and compare unit
// depends on bmhq_pkg and bmhq_ram
`timescale 1ns / 1ps

// Usage
//   Input stream: s_axis_tuser is the operation (0 push s_axis_tdata, 1 pop
//   the maximum); s_axis_tdata is the signed 32-bit value, ignored on pop.
//   Every input transaction gives exactly one output transaction carrying the
//   popped value (zero unless a pop succeeded), the new maximum (zero when
//   empty), the entry count, an empty flag and a status (ok, pop on empty
//   refused, push on full refused; a refused item leaves the heap as it was).
//   One item is in work at a time and s_axis_tready is low meanwhile.
//   The heap sits in a single ram with one read and one write port. For each
//   level it rises a push reads the parent, then compares and writes; for
//   each level it sinks a pop reads the left child, then the right child,
//   then compares and writes. A refused item or a pop of the last entry goes
//   straight to the result, and the block is ready for the next item as soon
//   as the result is offered, since the sequencer is then back in idle.
//   The result waits in an output register; while the receiver stalls the
//   finished item holds in its last state and no new item is taken.
//   Reset empties the queue at once; the ram holds no reset state.

module binary_max_heap_queue #(
  parameter int CAPACITY = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [bmhq_pkg::DATA_W-1:0]        s_axis_tdata,  // value
  input  logic                               s_axis_tuser,  // mode
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [bmhq_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,  // popped, top, count, pad
  output logic [bmhq_pkg::OUT_TUSER_W-1:0]   m_axis_tuser   // is_empty, status
);

  localparam int AW   = $clog2(CAPACITY + 1);
  localparam int DW   = bmhq_pkg::DATA_W;
  localparam int CNTW = bmhq_pkg::COUNT_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PUSH_RD,
    S_PUSH_CMP,
    S_POP_LAST,
    S_SINK_RDL,
    S_SINK_RDR,
    S_SINK_CMP,
    S_DONE
  } state_t;

  state_t                state;
  logic [AW-1:0]         count;
  logic [AW-1:0]         k;
  logic signed [DW-1:0]  v;
  logic signed [DW-1:0]  top;
  logic signed [DW-1:0]  left;
  logic                  has_right;
  logic signed [DW-1:0]  popped;
  bmhq_pkg::status_t     status;

  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [DW-1:0]         wr_data;
  logic [AW-1:0]         rd_addr;
  logic [DW-1:0]         rd_data;
  logic signed [DW-1:0]  rd_val;

  logic                  accept;
  logic [AW:0]           child;
  logic                  child_out;
  logic                  take_right;
  logic signed [DW-1:0]  best;
  logic                  v_stays;
  logic                  out_free;

  bmhq_ram #(
    .WIDTH (DW),
    .DEPTH (CAPACITY + 1)
  ) u_heap (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign rd_val        = $signed(rd_data);
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  // left child index, one bit wider so a leaf is detected
  assign child      = {k, 1'b0};
  assign child_out  = child > {1'b0, count};
  assign take_right = has_right && (left < rd_val);
  assign best       = take_right ? rd_val : left;
  assign v_stays    = take_right ? (v >= rd_val) : (v >= left);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = k;
    wr_data = v;
    rd_addr = '0;
    case (state)
      S_IDLE: begin
        rd_addr = count;
      end
      S_PUSH_RD: begin
        rd_addr = k >> 1;
        if (k == AW'(1)) begin
          wr_en = 1'b1;
        end
      end
      S_PUSH_CMP: begin
        wr_en = 1'b1;
        if (rd_val < v) begin
          wr_data = rd_data;
        end
      end
      S_SINK_RDL: begin
        rd_addr = child[AW-1:0];
        if (child_out) begin
          wr_en = 1'b1;
        end
      end
      S_SINK_RDR: begin
        rd_addr = child[AW-1:0] + AW'(1);
      end
      S_SINK_CMP: begin
        wr_en = 1'b1;
        if (!v_stays) begin
          wr_data = best;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      count         <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // a finished item in S_DONE reloads the output register itself
      if (m_axis_tvalid && m_axis_tready && state != S_DONE) begin
        m_axis_tvalid <= 1'b0;
      end
      if (wr_en && wr_addr == AW'(1)) begin
        top <= $signed(wr_data);
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            popped <= '0;
            status <= bmhq_pkg::ST_OK;
            k      <= AW'(1);
            if (!s_axis_tuser) begin
              if (count == AW'(CAPACITY)) begin
                status <= bmhq_pkg::ST_FULL;
                state  <= S_DONE;
              end else begin
                count <= count + AW'(1);
                k     <= count + AW'(1);
                v     <= $signed(s_axis_tdata);
                state <= S_PUSH_RD;
              end
            end else begin
              if (count == '0) begin
                status <= bmhq_pkg::ST_EMPTY;
                state  <= S_DONE;
              end else begin
                popped <= top;
                count  <= count - AW'(1);
                // last entry is being read for the new root
                state  <= (count == AW'(1)) ? S_DONE : S_POP_LAST;
              end
            end
          end
        end
        S_PUSH_RD: begin
          state <= (k == AW'(1)) ? S_DONE : S_PUSH_CMP;
        end
        S_PUSH_CMP: begin
          if (rd_val < v) begin
            k     <= k >> 1;
            state <= S_PUSH_RD;
          end else begin
            state <= S_DONE;
          end
        end
        S_POP_LAST: begin
          v     <= rd_val;
          state <= S_SINK_RDL;
        end
        S_SINK_RDL: begin
          state <= child_out ? S_DONE : S_SINK_RDR;
        end
        S_SINK_RDR: begin
          left      <= rd_val;
          has_right <= child < {1'b0, count};
          state     <= S_SINK_CMP;
        end
        S_SINK_CMP: begin
          if (v_stays) begin
            state <= S_DONE;
          end else begin
            k     <= take_right ? (child[AW-1:0] + AW'(1)) : child[AW-1:0];
            state <= S_SINK_RDL;
          end
        end
        S_DONE: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {1'b0, CNTW'(count),
                              (count == '0) ? {DW{1'b0}} : top, popped};
            m_axis_tuser  <= {status, (count == '0)};
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // the queue never holds more than its capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= AW'(CAPACITY))
    else $error("entry count beyond capacity");

  // heap writes only land on occupied positions
  a_write_range: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (wr_addr != '0) && (wr_addr <= count))
    else $error("heap write outside occupied positions");

  // an empty result reports a zero maximum
  a_empty_top: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[63:32] == '0))
    else $error("empty result with non-zero top");

endmodule

[hdl/bmhq_ram.sv]
// generic single write port, single read port ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module bmhq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[verif/binary_max_heap_queue_test.sv]
// self-checking bench for binary_max_heap_queue: stream driver, monitor and heap predictor
// depends on bmhq_pkg and the binary_max_heap_queue rtl
`timescale 1ns / 1ps

module binary_max_heap_queue_test;

  localparam int HEAP_CAP    = 64;
  localparam int CYCLE_LIMIT = 600000;
  localparam int QUIET_TAIL  = 150;   // last items go through without idling
  localparam int HOLD_AFTER  = 4000;  // cycles after reset before the long receiver hold
  localparam int HOLD_CYCLES = 300;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } heap_op_t;

  typedef struct packed {
    heap_op_t    op;
    logic [31:0] value;
  } heap_req_t;

  typedef struct packed {
    logic signed [31:0] popped;
    logic signed [31:0] top;
    logic [6:0]         count;
    logic               is_empty;
    bmhq_pkg::status_t  status;
  } heap_result_t;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              s_axis_tvalid = 1'b0;
  logic                              s_axis_tready;
  logic [bmhq_pkg::DATA_W-1:0]       s_axis_tdata = '0;   // value
  logic                              s_axis_tuser = 1'b0; // mode
  logic                              m_axis_tvalid;
  logic                              m_axis_tready = 1'b0;
  logic [bmhq_pkg::OUT_TDATA_W-1:0]  m_axis_tdata;        // popped, top, count, pad
  logic [bmhq_pkg::OUT_TUSER_W-1:0]  m_axis_tuser;        // is_empty, status

  binary_max_heap_queue #(
    .CAPACITY(HEAP_CAP)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  heap_req_t    pending_q[$];
  heap_result_t expected_q[$];
  int           fail_cnt = 0;
  logic         quiet = 1'b0;

  // predictor state: heap kept in positions 1..heap_cnt
  int heap_mem [1:HEAP_CAP];
  int heap_cnt = 0;

  task automatic heap_apply(input heap_op_t op, input logic [31:0] value,
                            output heap_result_t res);
    int k;
    int c;
    int t;
    res.popped = '0;
    res.status = bmhq_pkg::ST_OK;
    if (op == OP_PUSH) begin
      if (heap_cnt >= HEAP_CAP) begin
        res.status = bmhq_pkg::ST_FULL;
      end else begin
        heap_cnt++;
        heap_mem[heap_cnt] = value;
        k = heap_cnt;
        while (k > 1 && heap_mem[k / 2] < heap_mem[k]) begin
          t = heap_mem[k / 2];
          heap_mem[k / 2] = heap_mem[k];
          heap_mem[k] = t;
          k = k / 2;
        end
      end
    end else begin
      if (heap_cnt == 0) begin
        res.status = bmhq_pkg::ST_EMPTY;
      end else begin
        res.popped = heap_mem[1];
        heap_mem[1] = heap_mem[heap_cnt];
        heap_cnt--;
        k = 1;
        // sink toward the larger child, left one on a tie
        while (2 * k <= heap_cnt) begin
          c = 2 * k;
          if (c < heap_cnt && heap_mem[c] < heap_mem[c + 1]) c++;
          if (heap_mem[k] >= heap_mem[c]) break;
          t = heap_mem[k];
          heap_mem[k] = heap_mem[c];
          heap_mem[c] = t;
          k = c;
        end
      end
    end
    res.top      = (heap_cnt != 0) ? heap_mem[1] : 0;
    res.count    = heap_cnt[6:0];
    res.is_empty = (heap_cnt == 0);
  endtask

  function automatic logic [31:0] pick_value();
    int sel;
    sel = $urandom_range(0, 7);
    case (sel)
      0: begin
        case ($urandom_range(0, 3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      1, 2: return $urandom_range(0, 8) - 4;  // narrow range, many equal values
      default: return $urandom();
    endcase
  endfunction

  // driver
  heap_req_t    cur_req;
  heap_result_t pred_res;
  int           gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      gap_left = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        heap_apply(cur_req.op, cur_req.value, pred_res);
        expected_q.push_back(pred_res);
        if (!quiet && $urandom_range(0, 4) == 0) gap_left = $urandom_range(1, 15);
      end
      if (s_axis_tvalid && !s_axis_tready) begin
        // keep offering the same transaction
      end else if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_q.size() > 0) begin
        cur_req = pending_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= cur_req.value;
        s_axis_tuser  <= cur_req.op;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
      quiet <= (pending_q.size() < QUIET_TAIL);
    end
  end

  // long receiver hold so the output register stays full and the block stalls its input
  int hold_clk = 0;
  int hold_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      hold_clk  <= 0;
      hold_left <= 0;
    end else begin
      if (hold_clk < HOLD_AFTER) hold_clk <= hold_clk + 1;
      if (hold_clk == HOLD_AFTER - 1) begin
        hold_left <= HOLD_CYCLES;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
      end
    end
  end

  // monitor and receiver back-pressure
  heap_result_t want;
  heap_result_t got;
  int           stall_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.popped   = m_axis_tdata[31:0];
        got.top      = m_axis_tdata[63:32];
        got.count    = m_axis_tdata[70:64];
        got.is_empty = m_axis_tuser[0];
        got.status   = bmhq_pkg::status_t'(m_axis_tuser[2:1]);
        if (expected_q.size() == 0) begin
          $error("result transaction with nothing expected");
          fail_cnt++;
        end else begin
          want = expected_q.pop_front();
          if (got.popped !== want.popped) begin
            $error("popped: expected %0d, actual %0d", want.popped, got.popped);
            fail_cnt++;
          end
          if (got.top !== want.top) begin
            $error("top: expected %0d, actual %0d", want.top, got.top);
            fail_cnt++;
          end
          if (got.count !== want.count) begin
            $error("count: expected %0d, actual %0d", want.count, got.count);
            fail_cnt++;
          end
          if (got.is_empty !== want.is_empty) begin
            $error("is_empty: expected %0d, actual %0d", want.is_empty, got.is_empty);
            fail_cnt++;
          end
          if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            fail_cnt++;
          end
        end
      end
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 15) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic add_req(input heap_op_t op, input logic [31:0] value);
    heap_req_t r;
    r.op    = op;
    r.value = value;
    pending_q.push_back(r);
  endtask

  initial begin
    int total;
    int phase_len;
    int push_pct;
    int i;

    // directed: empty pop, extremes, ties at root and among children
    add_req(OP_POP,  32'hA5A5_5A5A);
    add_req(OP_PUSH, 32'h8000_0000);
    add_req(OP_PUSH, 32'h7FFF_FFFF);
    add_req(OP_PUSH, 32'h0000_0000);
    add_req(OP_PUSH, 32'hFFFF_FFFF);
    add_req(OP_PUSH, 32'h7FFF_FFFF);
    add_req(OP_PUSH, 32'd5);
    add_req(OP_PUSH, 32'd5);
    add_req(OP_PUSH, 32'd5);
    add_req(OP_PUSH, 32'd1);
    add_req(OP_PUSH, 32'h8000_0000);
    for (i = 0; i < 11; i++) add_req(OP_POP, 32'hFFFF_FFFF);
    add_req(OP_POP,  32'h0000_0000);
    add_req(OP_PUSH, 32'd3);
    add_req(OP_POP,  32'h5A5A_A5A5);

    // random phases: filling runs push toward full, draining runs pop toward empty, mixed runs do both evenly
    total = pending_q.size();
    while (total < 1800) begin
      phase_len = $urandom_range(20, 140);
      case ($urandom_range(0, 2))
        0: push_pct = 90;
        1: push_pct = 15;
        default: push_pct = 50;
      endcase
      for (i = 0; i < phase_len; i++) begin
        if ($urandom_range(1, 100) <= push_pct) add_req(OP_PUSH, pick_value());
        else add_req(OP_POP, $urandom());
      end
      total += phase_len;
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (pending_q.size() > 0 || s_axis_tvalid || expected_q.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);

    if (fail_cnt == 0) begin
      $display("PASS binary_max_heap_queue");
    end else begin
      $display("FAIL binary_max_heap_queue");
    end
    $finish;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $error("timeout with %0d results outstanding", expected_q.size());
    $display("FAIL binary_max_heap_queue");
    $finish;
  end

endmodule
